>>> hdl/bmpd_pkg.sv
// Shared types and constants for the 24-bit BMP stream decoder.
// No dependencies; imported by every module of the block.
package bmpd_pkg;

    // Parse phases
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_PIXELS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NOT_BMP     = 3'd0;
    localparam logic [2:0] ERR_SIZE        = 3'd1;
    localparam logic [2:0] ERR_INFO_HDR    = 3'd2;
    localparam logic [2:0] ERR_COMPRESSION = 3'd3;
    localparam logic [2:0] ERR_BIT_COUNT   = 3'd4;
    localparam logic [2:0] ERR_DIMENSIONS  = 3'd5;

    // Header byte offsets (file header then info header, little-endian)
    localparam logic [5:0] OFS_SIG      = 6'd0;
    localparam logic [5:0] OFS_SIZE     = 6'd2;
    localparam logic [5:0] OFS_INFO     = 6'd14;
    localparam logic [5:0] OFS_WIDTH    = 6'd18;
    localparam logic [5:0] OFS_HEIGHT   = 6'd22;
    localparam logic [5:0] OFS_BITS     = 6'd28;
    localparam logic [5:0] OFS_COMP     = 6'd30;
    localparam logic [5:0] IDX_FILE_END = 6'd13;
    localparam logic [5:0] IDX_INFO_END = 6'd53;

    // Expected header values
    localparam logic [15:0] BMP_SIGNATURE  = 16'h4D42;
    localparam logic [31:0] INFO_HDR_LEN   = 32'd40;
    localparam logic [15:0] BITS_24        = 16'd24;
    localparam logic [31:0] NO_COMPRESSION = 32'h0000_0000;

    typedef struct packed {
        logic        is_error;
        logic [2:0]  error_code;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic        last_pixel;
    } t_result;

endpackage

>>> hdl/bmpd_parser.sv
// Header capture/checks and pixel unpacking for the BMP stream decoder.
// Depends on bmpd_pkg. State advances only when i_step is high.
module bmpd_parser
    import bmpd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_sof,
    input  logic [31:0] i_file_length,
    output logic        o_res_vld,
    output t_result     o_res
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam logic [31:0] MAX_W32 = 32'(MAX_WIDTH);
    localparam logic [31:0] MAX_H32 = 32'(MAX_HEIGHT);

    logic [5:0]    r_idx,    n_idx;
    logic [1:0]    r_phase,  n_phase;
    logic [15:0]   r_sig,    n_sig;
    logic [31:0]   r_size,   n_size;
    logic [31:0]   r_info,   n_info;
    logic [31:0]   r_width,  n_width;
    logic [31:0]   r_height, n_height;
    logic [15:0]   r_bits,   n_bits;
    logic [31:0]   r_comp,   n_comp;
    logic [CW-1:0] r_col,    n_col;
    logic [RW-1:0] r_row,    n_row;
    logic [1:0]    r_bip,    n_bip;
    logic [1:0]    r_pad,    n_pad;
    logic [7:0]    r_blue,   n_blue;
    logic [7:0]    r_green,  n_green;

    logic [5:0] eff_idx;
    logic [1:0] eff_phase;
    logic [5:0] rel_sig, rel_size, rel_info, rel_width, rel_height, rel_bits, rel_comp;
    logic       last_col, last_row, bad_dims;

    always_comb begin
        eff_idx   = i_sof ? 6'd0 : r_idx;
        eff_phase = i_sof ? PH_HEADER : r_phase;
        rel_sig    = eff_idx - OFS_SIG;
        rel_size   = eff_idx - OFS_SIZE;
        rel_info   = eff_idx - OFS_INFO;
        rel_width  = eff_idx - OFS_WIDTH;
        rel_height = eff_idx - OFS_HEIGHT;
        rel_bits   = eff_idx - OFS_BITS;
        rel_comp   = eff_idx - OFS_COMP;
        last_col = (({1'b0, r_col} + (CW+1)'(1)) == r_width[CW:0]);
        last_row = (({1'b0, r_row} + (RW+1)'(1)) == r_height[RW:0]);
        bad_dims = (r_width == 32'd0) || (r_height == 32'd0) ||
                   (r_width > MAX_W32) || (r_height > MAX_H32);
    end

    always_comb begin
        n_idx = r_idx;     n_phase = r_phase;
        n_sig = r_sig;     n_size = r_size;   n_info = r_info;
        n_width = r_width; n_height = r_height;
        n_bits = r_bits;   n_comp = r_comp;
        n_col = r_col;     n_row = r_row;     n_bip = r_bip;  n_pad = r_pad;
        n_blue = r_blue;   n_green = r_green;
        o_res_vld = 1'b0;
        o_res     = '0;

        if (eff_phase == PH_HEADER) begin
            n_phase = PH_HEADER;
            n_idx   = eff_idx + 6'd1;
            // lanes are written in order from byte 0, so no clearing needed
            case (eff_idx) inside
                [OFS_SIG:OFS_SIG+6'd1]:        n_sig[8*rel_sig[0] +: 8] = i_byte;
                [OFS_SIZE:OFS_SIZE+6'd3]:      n_size[8*rel_size[1:0] +: 8] = i_byte;
                [OFS_INFO:OFS_INFO+6'd3]:      n_info[8*rel_info[1:0] +: 8] = i_byte;
                [OFS_WIDTH:OFS_WIDTH+6'd3]:    n_width[8*rel_width[1:0] +: 8] = i_byte;
                [OFS_HEIGHT:OFS_HEIGHT+6'd3]:  n_height[8*rel_height[1:0] +: 8] = i_byte;
                [OFS_BITS:OFS_BITS+6'd1]:      n_bits[8*rel_bits[0] +: 8] = i_byte;
                [OFS_COMP:OFS_COMP+6'd3]:      n_comp[8*rel_comp[1:0] +: 8] = i_byte;
                default: ;
            endcase

            if (eff_idx == IDX_FILE_END) begin
                if (r_sig != BMP_SIGNATURE) begin
                    o_res_vld = 1'b1; o_res.error_code = ERR_NOT_BMP;
                end else if (r_size != i_file_length) begin
                    o_res_vld = 1'b1; o_res.error_code = ERR_SIZE;
                end
            end else if (eff_idx == IDX_INFO_END) begin
                if (r_info != INFO_HDR_LEN) begin
                    o_res_vld = 1'b1; o_res.error_code = ERR_INFO_HDR;
                end else if (r_comp != NO_COMPRESSION) begin
                    o_res_vld = 1'b1; o_res.error_code = ERR_COMPRESSION;
                end else if (r_bits != BITS_24) begin
                    o_res_vld = 1'b1; o_res.error_code = ERR_BIT_COUNT;
                end else if (bad_dims) begin
                    o_res_vld = 1'b1; o_res.error_code = ERR_DIMENSIONS;
                end else begin
                    n_phase = PH_PIXELS;
                    n_col = '0; n_row = '0; n_bip = 2'd0; n_pad = 2'd0;
                end
            end
            if (o_res_vld) begin
                o_res.is_error = 1'b1;
                n_phase = PH_DONE;
            end
        end else if (eff_phase == PH_PIXELS) begin
            if (r_pad != 2'd0) begin
                n_pad = r_pad - 2'd1;
                if (r_pad == 2'd1) begin
                    n_col = '0;
                    n_row = r_row + RW'(1);
                end
            end else begin
                case (r_bip)
                    2'd0: begin
                        n_blue = i_byte;
                        n_bip  = 2'd1;
                    end
                    2'd1: begin
                        n_green = i_byte;
                        n_bip   = 2'd2;
                    end
                    default: begin
                        n_bip = 2'd0;
                        o_res_vld        = 1'b1;
                        o_res.red        = i_byte;
                        o_res.green      = r_green;
                        o_res.blue       = r_blue;
                        o_res.column     = 12'(r_col);
                        // rows arrive bottom first; flip to top-down
                        o_res.row        = r_height[11:0] - 12'd1 - 12'(r_row);
                        o_res.last_pixel = last_col && last_row;
                        if (last_col) begin
                            if (last_row) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_pad = r_width[1:0];
                                if (r_width[1:0] == 2'd0) begin
                                    n_col = '0;
                                    n_row = r_row + RW'(1);
                                end
                            end
                        end else begin
                            n_col = r_col + CW'(1);
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_phase <= PH_HEADER;
            r_col   <= '0;
            r_row   <= '0;
            r_bip   <= 2'd0;
            r_pad   <= 2'd0;
        end else if (i_step) begin
            r_idx   <= n_idx;
            r_phase <= n_phase;
            r_col   <= n_col;
            r_row   <= n_row;
            r_bip   <= n_bip;
            r_pad   <= n_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_sig    <= n_sig;
            r_size   <= n_size;
            r_info   <= n_info;
            r_width  <= n_width;
            r_height <= n_height;
            r_bits   <= n_bits;
            r_comp   <= n_comp;
            r_blue   <= n_blue;
            r_green  <= n_green;
        end
    end

endmodule

>>> hdl/bmpd_out_stage.sv
// Output register for decoded results; frees itself when the sink takes the transfer.
// Depends on bmpd_pkg for the result struct.
module bmpd_out_stage
    import bmpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_vld,
    output t_result o_res
);

    logic    r_vld;
    t_result r_res;

    assign o_free = !r_vld || i_ready;
    assign o_vld  = r_vld;
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> hdl/bmp24_stream_decoder.sv
// Path: an input transfer lands in the input register, which feeds the parser; a result
//   is then loaded into the output register, which drives the master side.
// Throughput: one byte per cycle; bytes that yield no result never wait on the sink,
//   bytes that yield a result wait only while the output register is full and stalled.
// Reset: synchronous active-low i_rst_n clears the parser to the header phase,
//   empties the input and output registers and sets file_length to zero.
// Depends on bmpd_pkg, bmpd_parser and bmpd_out_stage.
module bmp24_stream_decoder
    import bmpd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: file_length
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] start_of_file
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // [2:0] error_code, [10:3] red, [18:11] green,
                                          // [26:19] blue, [38:27] column, [50:39] row
    output logic        o_m_axis_tuser,   // [0] is_error
    output logic        o_m_axis_tlast    // last_pixel
);

    logic [31:0] r_file_length;

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_sof;

    logic    res_vld;
    t_result res;
    logic    out_free;
    logic    out_vld;
    t_result out_res;
    logic    advance;

    // Config writes must be made only while idle; the block does not enforce this. The port is always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_length <= 32'd0;
        end else if (i_cfg_valid) begin
            r_file_length <= i_cfg_data;
        end
    end

    // A held byte moves on when it makes no result or the output slot is free.
    assign advance         = r_in_vld && (out_free || !res_vld);
    assign o_s_axis_tready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_sof  <= i_s_axis_tuser;
        end
    end

    bmpd_parser #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_byte        (r_in_byte),
        .i_sof         (r_in_sof),
        .i_file_length (r_file_length),
        .o_res_vld     (res_vld),
        .o_res         (res)
    );

    bmpd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_vld),
        .i_res   (res),
        .i_ready (i_m_axis_tready),
        .o_free  (out_free),
        .o_vld   (out_vld),
        .o_res   (out_res)
    );

    assign o_m_axis_tvalid = out_vld;
    assign o_m_axis_tuser  = out_res.is_error;
    assign o_m_axis_tlast  = out_res.last_pixel;
    assign o_m_axis_tdata  = {5'd0, out_res.row, out_res.column, out_res.blue,
                              out_res.green, out_res.red, out_res.error_code};

`ifndef SYNTHESIS
    // An error transfer never carries the last-pixel mark.
    a_err_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> !o_m_axis_tlast)
        else $error("error result marked as last pixel");

    // Error codes stay within the defined set.
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[2:0] <= ERR_DIMENSIONS)
        else $error("error code out of range");

    // A byte with a pending result stalls in the input register while the sink stalls.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && res_vld && out_vld && !i_m_axis_tready
        |=> r_in_vld && $stable(r_in_byte) && $stable(r_in_sof))
        else $error("byte with pending result lost during stall");

    // A result is loaded only into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && res_vld |-> !out_vld || i_m_axis_tready)
        else $error("output register overwritten");
`endif

endmodule

>>> tb/sv/bmp24_stream_decoder_chk.sv
// Result checker for bmp24_stream_decoder: follows the config, byte and result channels,
// decodes each accepted byte on its own copy of the parser state and compares every result.
// Depends on bmpd_pkg (phases, error codes, header offsets, t_result).
module bmp24_stream_decoder_chk
    import bmpd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,
    input  logic        i_m_tuser,
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    logic [31:0] file_len;

    // parser copy
    logic [5:0]  hdr_idx;
    logic [1:0]  phase;
    logic [15:0] sig;
    logic [31:0] decl_size;
    logic [31:0] info_len;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [15:0] bits;
    logic [31:0] comp;
    logic [11:0] col;
    logic [11:0] frow;
    logic [1:0]  bip;
    logic [1:0]  pad;
    logic [7:0]  blue_q;
    logic [7:0]  green_q;

    t_result decoded_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void clear_parse();
        hdr_idx = '0; phase = PH_HEADER;
        sig = '0; decl_size = '0; info_len = '0;
        img_w = '0; img_h = '0; bits = '0; comp = '0;
        col = '0; frow = '0; bip = '0; pad = '0;
        blue_q = '0; green_q = '0;
    endfunction

    // OR a byte into a little-endian field when idx falls inside [base, base+len)
    function automatic logic [31:0] le_merge(input logic [31:0] field, input logic [7:0] b,
                                             input logic [5:0] idx, input logic [5:0] base,
                                             input int len);
        int k;
        k = int'(idx) - int'(base);
        if (k >= 0 && k < len)
            return field | ({24'd0, b} << (8 * k));
        return field;
    endfunction

    function automatic logic raise_error(inout t_result r, input logic [2:0] code);
        r.is_error   = 1'b1;
        r.error_code = code;
        phase        = PH_DONE;
        return 1'b1;
    endfunction

    // One accepted byte; returns 1 when it yields a result in r
    function automatic logic decode_byte(input logic [7:0] b, input logic sof,
                                         output t_result r);
        logic [5:0]  i;
        logic [31:0] t;
        logic        last_col;
        logic        last_row;
        r = '0;
        if (sof)
            clear_parse();

        if (phase == PH_HEADER) begin
            i = hdr_idx;
            t = le_merge({16'd0, sig}, b, i, OFS_SIG, 2);
            sig = t[15:0];
            decl_size = le_merge(decl_size, b, i, OFS_SIZE, 4);
            info_len  = le_merge(info_len, b, i, OFS_INFO, 4);
            img_w     = le_merge(img_w, b, i, OFS_WIDTH, 4);
            img_h     = le_merge(img_h, b, i, OFS_HEIGHT, 4);
            t = le_merge({16'd0, bits}, b, i, OFS_BITS, 2);
            bits = t[15:0];
            comp      = le_merge(comp, b, i, OFS_COMP, 4);
            hdr_idx   = i + 6'd1;
            if (i == IDX_FILE_END) begin
                if (sig != BMP_SIGNATURE) return raise_error(r, ERR_NOT_BMP);
                if (decl_size != file_len) return raise_error(r, ERR_SIZE);
            end else if (i == IDX_INFO_END) begin
                if (info_len != INFO_HDR_LEN) return raise_error(r, ERR_INFO_HDR);
                if (comp != NO_COMPRESSION) return raise_error(r, ERR_COMPRESSION);
                if (bits != BITS_24) return raise_error(r, ERR_BIT_COUNT);
                if (img_w == 32'd0 || img_h == 32'd0 ||
                    img_w > 32'(MAX_WIDTH) || img_h > 32'(MAX_HEIGHT))
                    return raise_error(r, ERR_DIMENSIONS);
                phase = PH_PIXELS;
                col = '0; frow = '0; bip = '0; pad = '0;
            end
            return 1'b0;
        end

        if (phase != PH_PIXELS)
            return 1'b0;

        // row padding
        if (pad != 2'd0) begin
            pad = pad - 2'd1;
            if (pad == 2'd0) begin
                col  = '0;
                frow = frow + 12'd1;
            end
            return 1'b0;
        end

        if (bip == 2'd0) begin
            blue_q = b; bip = 2'd1;
            return 1'b0;
        end
        if (bip == 2'd1) begin
            green_q = b; bip = 2'd2;
            return 1'b0;
        end
        bip = 2'd0;

        last_col     = ({20'd0, col} + 32'd1 == img_w);
        last_row     = ({20'd0, frow} + 32'd1 == img_h);
        r.red        = b;
        r.green      = green_q;
        r.blue       = blue_q;
        r.column     = col;
        t            = img_h - 32'd1 - {20'd0, frow};
        r.row        = t[11:0];
        r.last_pixel = last_col && last_row;

        if (last_col) begin
            if (last_row) begin
                phase = PH_DONE;
            end else begin
                pad = img_w[1:0];
                if (pad == 2'd0) begin
                    col  = '0;
                    frow = frow + 12'd1;
                end
            end
        end else begin
            col = col + 12'd1;
        end
        return 1'b1;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", fname, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            file_len = '0;
            clear_parse();
            decoded_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                file_len = i_cfg_data;

            if (i_s_tvalid && i_s_tready) begin
                if (decode_byte(i_s_tdata, i_s_tuser, want))
                    decoded_q.push_back(want);
            end

            if (i_m_tvalid && i_m_tready) begin
                got.is_error   = i_m_tuser;
                got.error_code = i_m_tdata[2:0];
                got.red        = i_m_tdata[10:3];
                got.green      = i_m_tdata[18:11];
                got.blue       = i_m_tdata[26:19];
                got.column     = i_m_tdata[38:27];
                got.row        = i_m_tdata[50:39];
                got.last_pixel = i_m_tlast;
                if (decoded_q.size() == 0) begin
                    $error("unexpected result transfer: tuser %0h tdata %0h tlast %0h",
                           i_m_tuser, i_m_tdata, i_m_tlast);
                    o_fail_count++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("is_error", 32'(want.is_error), 32'(got.is_error));
                    check_field("error_code", 32'(want.error_code), 32'(got.error_code));
                    check_field("red", 32'(want.red), 32'(got.red));
                    check_field("green", 32'(want.green), 32'(got.green));
                    check_field("blue", 32'(want.blue), 32'(got.blue));
                    check_field("column", 32'(want.column), 32'(got.column));
                    check_field("row", 32'(want.row), 32'(got.row));
                    check_field("last_pixel", 32'(want.last_pixel), 32'(got.last_pixel));
                end
            end
        end
        o_pending = decoded_q.size();
    end

endmodule

>>> tb/sv/bmp24_stream_decoder_tb.sv
// Top of the bmp24_stream_decoder bench: clock, reset, BMP file stimulus, sink stalls, verdict.
// Depends on bmpd_pkg, bmp24_stream_decoder and bmp24_stream_decoder_chk.
module bmp24_stream_decoder_tb;
    import bmpd_pkg::*;

    localparam int MAX_W       = 4096;
    localparam int MAX_H       = 4096;
    localparam int HOLD_CYCLES = 600;   // long sink hold-off, fills the pipe
    localparam int RAND_BYTES  = 200;

    typedef enum int {SC_GOOD, SC_CORRUPT, SC_SHORT, SC_TAIL, SC_NOISE} file_kind_t;
    typedef enum int {SINK_OPEN, SINK_MOSTLY, SINK_SPARSE, SINK_COMB} sink_mode_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data  = '0;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_data    = '0;
    logic        s_sof     = 1'b0;
    logic        m_ready   = 1'b0;

    logic        cfg_ready;
    logic        s_ready;
    logic        m_valid;
    logic [55:0] m_data;
    logic        m_user;
    logic        m_last;

    int          chk_fails;
    int          chk_pending;

    int          burst_left = 0;   // transfers left in the current sender burst
    int          sent_count = 0;
    logic        hold_go    = 1'b0;

    bmp24_stream_decoder #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_sof),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user),
        .o_m_axis_tlast (m_last)
    );

    bmp24_stream_decoder_chk #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) decode_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_valid),
        .i_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_sof),
        .i_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .i_m_tdata   (m_data),
        .i_m_tuser   (m_user),
        .i_m_tlast   (m_last),
        .o_fail_count(chk_fails),
        .o_pending   (chk_pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #20_000_000;
        $display("FAIL bmp24_stream_decoder");
        $finish;
    end

    // Declared size of a well-formed 24-bit file; rows pad by width & 3
    function automatic logic [31:0] bmp_size(input int w, input int h);
        return 32'(54 + (3 * w + (w & 3)) * h);
    endfunction

    // One byte transfer. Inputs change on the falling edge; tready is
    // sampled on the rising edge. Gaps come between random bursts.
    task automatic send_byte(input logic [7:0] d, input logic sof);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= d;
        s_sof   <= sof;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        sent_count++;
    endtask

    // Drop valid, let every result drain, then give the pipe a few more cycles
    // so that a byte with no result is done before the register changes.
    task automatic settle();
        @(negedge clk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (chk_pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_file_length(input logic [31:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Header with the given fields (other header bytes random), then up to
    // keep bytes of pixel data (keep < 0: the full body), then tail extra bytes.
    task automatic send_bmp(input logic [15:0] sig, input logic [31:0] size,
                            input logic [31:0] info, input logic [31:0] w,
                            input logic [31:0] h, input logic [15:0] bits,
                            input logic [31:0] comp, input longint keep, input int tail);
        logic [54*8-1:0] hdr;
        longint          body;
        for (int k = 0; k < 54; k++)
            hdr[8*k +: 8] = 8'($urandom);
        hdr[8*OFS_SIG    +: 16] = sig;
        hdr[8*OFS_SIZE   +: 32] = size;
        hdr[8*OFS_INFO   +: 32] = info;
        hdr[8*OFS_WIDTH  +: 32] = w;
        hdr[8*OFS_HEIGHT +: 32] = h;
        hdr[8*OFS_BITS   +: 16] = bits;
        hdr[8*OFS_COMP   +: 32] = comp;
        body = (longint'(w) * 3 + longint'(w & 32'd3)) * longint'(h);
        if (keep >= 0 && keep < body)
            body = keep;
        for (int k = 0; k < 54; k++)
            send_byte(hdr[8*k +: 8], k == 0);
        for (longint n = 0; n < body; n++)
            send_byte(8'($urandom), 1'b0);
        repeat (tail) send_byte(8'($urandom), 1'b0);
    endtask

    // Sink: changing stall patterns, plus one long hold-off on request
    initial begin : sink
        sink_mode_t mode;
        int         left;
        int         cyc;
        mode = SINK_OPEN;
        left = 0;
        cyc  = 0;
        forever begin
            @(negedge clk);
            cyc++;
            if (hold_go) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_go = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = sink_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(20, 200);
                end
                left--;
                case (mode)
                    SINK_OPEN:   m_ready <= 1'b1;
                    SINK_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                    SINK_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:     m_ready <= (cyc % 5 != 0);
                endcase
            end
        end
    end

    initial begin : stim
        logic [31:0] decl;
        logic [15:0] sig;
        logic [31:0] size;
        logic [31:0] info;
        logic [31:0] fw;
        logic [31:0] fh;
        logic [15:0] bits;
        logic [31:0] comp;
        longint      keep;
        int          tail;
        int          w;
        int          h;
        int          roll;
        file_kind_t  kind;
        int          k;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed ----
        // garbage before any start of file: parsed as a header, fails at byte 13
        repeat (16) send_byte(8'($urandom), 1'b0);

        decl = bmp_size(2, 2);
        write_file_length(decl);
        // good 2x2 with bytes after the last pixel
        send_bmp(BMP_SIGNATURE, decl, INFO_HDR_LEN, 2, 2, BITS_24, NO_COMPRESSION, -1, 5);
        // each header check on its own, info size beating compression among them
        send_bmp(16'h4D43, decl, INFO_HDR_LEN, 2, 2, BITS_24, NO_COMPRESSION, -1, 3);
        send_bmp(BMP_SIGNATURE, decl + 1, INFO_HDR_LEN, 2, 2, BITS_24, NO_COMPRESSION, -1, 0);
        send_bmp(BMP_SIGNATURE, decl, 32'd12, 2, 2, BITS_24, NO_COMPRESSION, -1, 0);
        send_bmp(BMP_SIGNATURE, decl, 32'd12, 2, 2, BITS_24, 32'd1, 4, 0);
        send_bmp(BMP_SIGNATURE, decl, INFO_HDR_LEN, 2, 2, BITS_24, 32'd1, 4, 0);
        send_bmp(BMP_SIGNATURE, decl, INFO_HDR_LEN, 2, 2, 16'd32, NO_COMPRESSION, 4, 0);
        // zero, oversized and negative (top-down) dimensions
        send_bmp(BMP_SIGNATURE, decl, INFO_HDR_LEN, 0, 2, BITS_24, NO_COMPRESSION, 4, 0);
        send_bmp(BMP_SIGNATURE, decl, INFO_HDR_LEN, 2, 0, BITS_24, NO_COMPRESSION, 4, 0);
        send_bmp(BMP_SIGNATURE, decl, INFO_HDR_LEN, 4097, 2, BITS_24, NO_COMPRESSION, 4, 0);
        send_bmp(BMP_SIGNATURE, decl, INFO_HDR_LEN, 2, 4097, BITS_24, NO_COMPRESSION, 4, 0);
        send_bmp(BMP_SIGNATURE, decl, INFO_HDR_LEN, 2, 32'hFFFF_FFFE, BITS_24,
                 NO_COMPRESSION, 4, 0);
        // short file cut mid-row, restarted by the next start of file
        send_bmp(BMP_SIGNATURE, decl, INFO_HDR_LEN, 2, 2, BITS_24, NO_COMPRESSION, 11, 0);
        send_bmp(BMP_SIGNATURE, decl, INFO_HDR_LEN, 2, 2, BITS_24, NO_COMPRESSION, -1, 0);

        // largest image and all-ones length: the first 16 pixels of the bottom row,
        // with the long sink hold-off while the pixels flow
        write_file_length(32'hFFFF_FFFF);
        hold_go = 1'b1;
        send_bmp(BMP_SIGNATURE, 32'hFFFF_FFFF, INFO_HDR_LEN, MAX_W, MAX_H, BITS_24,
                 NO_COMPRESSION, 3 * 16, 0);

        // zero length register, 1x1 image, padding after the last pixel
        write_file_length(32'd0);
        send_bmp(BMP_SIGNATURE, 32'd0, INFO_HDR_LEN, 1, 1, BITS_24, NO_COMPRESSION, -1, 2);
        // no row padding (width multiple of 4)
        decl = bmp_size(4, 2);
        write_file_length(decl);
        send_bmp(BMP_SIGNATURE, decl, INFO_HDR_LEN, 4, 2, BITS_24, NO_COMPRESSION, -1, 0);
        decl = bmp_size(3, 3);
        write_file_length(decl);
        send_bmp(BMP_SIGNATURE, decl, INFO_HDR_LEN, 3, 3, BITS_24, NO_COMPRESSION, -1, 0);

        // ---- random ----
        // Each phase: one length setting, then a few files of one size,
        // mostly well-formed, some broken, cut short, padded or pure noise.
        sent_count = 0;
        while (sent_count < RAND_BYTES) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 4);
            decl = bmp_size(w, h);
            write_file_length(($urandom_range(0, 7) == 0) ? 32'($urandom) : decl);
            repeat ($urandom_range(1, 4)) begin
                roll = $urandom_range(0, 8);
                kind = (roll < 5) ? SC_GOOD : file_kind_t'(roll - 4);
                sig  = BMP_SIGNATURE;
                size = decl;
                info = INFO_HDR_LEN;
                fw   = w;
                fh   = h;
                bits = BITS_24;
                comp = NO_COMPRESSION;
                keep = -1;
                tail = 0;
                case (kind)
                    SC_CORRUPT: begin
                        keep = $urandom_range(0, 8);
                        case ($urandom_range(0, 5))
                            0: sig  = 16'($urandom);
                            1: size = decl ^ (32'd1 << $urandom_range(0, 31));
                            2: info = 32'($urandom);
                            3: comp = 32'($urandom_range(1, 6));
                            4: bits = 16'($urandom);
                            default: begin
                                case ($urandom_range(0, 3))
                                    0: fw = 32'd0;
                                    1: fh = 32'd0;
                                    2: fw = 32'(MAX_W + 1) + 32'($urandom_range(0, 1000));
                                    default: fh = 32'hFFFF_FFFF - 32'($urandom_range(0, 100));
                                endcase
                            end
                        endcase
                    end
                    SC_SHORT: keep = $urandom_range(0, decl - 55);
                    SC_TAIL:  tail = $urandom_range(1, 8);
                    default: ;
                endcase
                if (kind == SC_NOISE) begin
                    repeat ($urandom_range(1, 30))
                        send_byte(8'($urandom), $urandom_range(0, 7) == 0);
                end else begin
                    send_bmp(sig, size, info, fw, fh, bits, comp, keep, tail);
                end
            end
        end

        // ---- drain and verdict ----
        @(negedge clk);
        s_valid <= 1'b0;
        for (k = 0; k < 5000 && chk_pending != 0; k++) @(negedge clk);
        repeat (10) @(negedge clk);
        if (chk_pending != 0)
            $error("%0d expected results never arrived", chk_pending);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("PASS bmp24_stream_decoder");
        end else begin
            $display("FAIL bmp24_stream_decoder");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/bmpd_pkg.sv
hdl/bmpd_parser.sv
hdl/bmpd_out_stage.sv
hdl/bmp24_stream_decoder.sv
tb/sv/bmp24_stream_decoder_chk.sv
tb/sv/bmp24_stream_decoder_tb.sv
